/* hw/rtl/lpwq_pkg.sv */
package lpwq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 512;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int WAIT_W     = 4;
    localparam int FILL_W     = 10;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    localparam logic [WAIT_W-1:0] CMD_WAIT_RESET = 4'd4;

    // Input operation selector
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_PUSH_CHAR = 2'd1,
        OP_PUSH_CMD  = 2'd2
    } op_t;

    // One queue entry: command flag over the byte
    typedef struct packed {
        logic              is_cmd;
        logic [BYTE_W-1:0] data;
    } entry_t;

    // Queue status seen by the control logic
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
    } queue_stat_t;

endpackage

/* hw/rtl/lpwq_queue.sv */
module lpwq_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_en,
    input  lpwq_pkg::entry_t      push_entry,
    input  logic                  pop_en,
    output lpwq_pkg::entry_t      head_entry,
    output lpwq_pkg::queue_stat_t stat
);
    import lpwq_pkg::*;

    entry_t            mem [QUEUE_DEPTH];
    entry_t            mem_q_reg;
    entry_t            byp_data_reg;
    logic              byp_hit_reg;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Pointer and count updates
    always_comb begin
        rd_ptr_next = pop_en  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = push_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        count_next  = count_reg;
        if (push_en) begin
            count_next = count_reg + 1'b1;
        end else if (pop_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            byp_hit_reg <= 1'b0;
        end else begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            count_reg   <= count_next;
            // write landing on the next head: memory reads old data this edge
            byp_hit_reg <= push_en && (wr_ptr_reg == rd_ptr_next);
        end
    end

    // Storage: one write port, one registered read of the next head every cycle
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[wr_ptr_reg] <= push_entry;
        end
        mem_q_reg    <= mem[rd_ptr_next];
        byp_data_reg <= push_entry;
    end

    assign head_entry  = byp_hit_reg ? byp_data_reg : mem_q_reg;
    assign stat.count  = count_reg;
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

/* hw/rtl/lcd_paced_write_queue.sv */
// A result is registered on acceptance of its input transaction and shown the cycle after.
// Throughput: one transaction per cycle while the result stream does not stall; the queue
// memory is read once per cycle at the next head address, bypassing a write to that slot.
// Reset (aresetn low, synchronous): queue empty, wait counter and chaser zero,
// command wait register back to 4, no result pending. Queue contents not cleared.
module lcd_paced_write_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [lpwq_pkg::WAIT_W-1:0]        cfg_wdata,   // command_wait_ticks
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lpwq_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] byte_in
    input  logic [lpwq_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [1:0] op
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] write_strobe, [1] register_select, [9:2] lcd_byte, [17:10] led_drive,
    // [18] push_dropped, [28:19] queue_fill, [31:29] zero
    output logic [lpwq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import lpwq_pkg::*;

    logic [WAIT_W-1:0]     cmd_wait_reg;
    logic [WAIT_W-1:0]     wait_reg, wait_next;
    logic [BYTE_W-1:0]     chaser_reg, chaser_next;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic        accept;
    op_t         op;
    logic        push_en, pop_en;
    entry_t      push_entry, head_entry;
    queue_stat_t q_stat;
    logic [CNT_W-1:0]  fill_after;
    logic              strobe, rs, dropped;
    logic [BYTE_W-1:0] lcd_byte;

    // Handshake: output register frees up when its transaction is taken
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser);

    lpwq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (push_en),
        .push_entry (push_entry),
        .pop_en     (pop_en),
        .head_entry (head_entry),
        .stat       (q_stat)
    );

    assign push_entry.is_cmd = (op == OP_PUSH_CMD);
    assign push_entry.data   = s_axis_tdata;

    // Per-transaction decode
    always_comb begin
        push_en     = 1'b0;
        pop_en      = 1'b0;
        strobe      = 1'b0;
        rs          = 1'b0;
        lcd_byte    = '0;
        dropped     = 1'b0;
        wait_next   = wait_reg;
        chaser_next = chaser_reg;
        if (accept) begin
            case (op)
                OP_TICK: begin
                    chaser_next = (|chaser_reg[6:0]) ? {chaser_reg[6:0], 1'b0}
                                                     : 8'h01;
                    if (!q_stat.empty) begin
                        if (wait_reg == '0) begin
                            pop_en    = 1'b1;
                            strobe    = 1'b1;
                            rs        = !head_entry.is_cmd;
                            lcd_byte  = head_entry.data;
                            wait_next = head_entry.is_cmd ? cmd_wait_reg : '0;
                        end else begin
                            wait_next = wait_reg - 1'b1;
                        end
                    end
                end
                OP_PUSH_CHAR, OP_PUSH_CMD: begin
                    if (q_stat.full) begin
                        dropped = 1'b1;
                    end else begin
                        push_en = 1'b1;
                    end
                end
                default: begin
                    // unused selector: no effect
                end
            endcase
        end
    end

    // Fill level after this transaction
    always_comb begin
        fill_after = q_stat.count;
        if (push_en) begin
            fill_after = q_stat.count + 1'b1;
        end else if (pop_en) begin
            fill_after = q_stat.count - 1'b1;
        end
    end

    assign m_data_next = {3'b000, FILL_W'(fill_after), dropped, ~chaser_next,
                          lcd_byte, rs, strobe};

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_wait_reg <= CMD_WAIT_RESET;
            wait_reg     <= '0;
            chaser_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cmd_wait_reg <= cfg_wdata;
            end
            wait_reg   <= wait_next;
            chaser_reg <= chaser_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_en |=> q_stat.count == $past(q_stat.count) - 1'b1)
        else $error("pop did not decrement count");

    a_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (op == OP_PUSH_CHAR || op == OP_PUSH_CMD) && q_stat.full
        |=> m_axis_tvalid && m_axis_tdata[18] && $stable(q_stat.count))
        else $error("full push not flagged or queue changed");

    a_no_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[9:1] == '0)
        else $error("bus fields nonzero without strobe");

endmodule

/* tb/sv/lcd_paced_write_queue_test.sv */
module lcd_paced_write_queue_test;
    import lpwq_pkg::*;

    // Selector value with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_DIRECTED = 25;
    localparam int RUN_LIMIT  = 2_000_000;

    // One result transaction, most significant field first
    typedef struct packed {
        logic [OUT_DATA_W-FILL_W-2*BYTE_W-4:0] pad;
        logic [FILL_W-1:0]                     fill;
        logic                                  dropped;
        logic [BYTE_W-1:0]                     led;
        logic [BYTE_W-1:0]                     lcd;
        logic                                  rs;
        logic                                  strobe;
    } lcd_out_t;

    // Directed stimulus row; want is used only where known is set
    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] din;
        logic              known;
        lcd_out_t          want;
    } lcd_row_t;

    localparam lcd_out_t NO_RES = '0;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [WAIT_W-1:0]     cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    lcd_paced_write_queue uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the queue and pacing state
    entry_t            shadow_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] rd_pos;
    logic [ADDR_W-1:0] wr_pos;
    logic [CNT_W-1:0]  queued;
    logic [WAIT_W-1:0] pause_ticks;
    logic [WAIT_W-1:0] cmd_wait;
    logic [BYTE_W-1:0] chaser;

    lcd_out_t pending_lcd_results [$];
    int       mismatch_count = 0;
    bit       idle_on = 1'b1;
    int       rx_hold = 0;
    lcd_row_t directed_rows [N_DIRECTED];
    lcd_out_t got;
    lcd_out_t want;

    function automatic lcd_out_t lcd_res(input logic strobe, input logic rs,
                                         input logic [BYTE_W-1:0] lcd,
                                         input logic [BYTE_W-1:0] led,
                                         input logic dropped,
                                         input logic [FILL_W-1:0] fill);
        lcd_out_t r;
        r = '0;
        r.strobe  = strobe;
        r.rs      = rs;
        r.lcd     = lcd;
        r.led     = led;
        r.dropped = dropped;
        r.fill    = fill;
        return r;
    endfunction

    // Advance the shadow state by one transaction and return the LCD-side result
    function automatic lcd_out_t next_lcd_result(input logic [1:0] op,
                                                 input logic [BYTE_W-1:0] din);
        lcd_out_t r;
        entry_t   head;
        r = '0;
        case (op)
            OP_TICK: begin
                chaser = (chaser[6:0] != '0) ? {chaser[6:0], 1'b0} : 8'h01;
                if (queued != '0) begin
                    if (pause_ticks == '0) begin
                        head   = shadow_mem[rd_pos];
                        rd_pos = (rd_pos == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_pos + 1'b1;
                        queued = queued - 1'b1;
                        r.strobe    = 1'b1;
                        r.rs        = ~head.is_cmd;
                        r.lcd       = head.data;
                        pause_ticks = head.is_cmd ? cmd_wait : '0;
                    end else begin
                        pause_ticks = pause_ticks - 1'b1;
                    end
                end
            end
            OP_PUSH_CHAR, OP_PUSH_CMD: begin
                if (queued >= CNT_W'(QUEUE_DEPTH)) begin
                    r.dropped = 1'b1;
                end else begin
                    shadow_mem[wr_pos].is_cmd = (op == OP_PUSH_CMD);
                    shadow_mem[wr_pos].data   = din;
                    wr_pos = (wr_pos == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
                    queued = queued + 1'b1;
                end
            end
            default: ;
        endcase
        r.led  = ~chaser;
        r.fill = FILL_W'(queued);
        return r;
    endfunction

    // Present one transaction, wait for acceptance, record what must come back
    task automatic send_item(input logic [1:0] op, input logic [BYTE_W-1:0] din,
                             input logic known, input lcd_out_t typed);
        lcd_out_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= din;
        do @(posedge aclk); while (!s_axis_tready);
        predicted = next_lcd_result(op, din);
        pending_lcd_results.push_back(known ? typed : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_lcd_results.size() != 0) @(posedge aclk);
    endtask

    // Register writes only once the block has nothing in flight
    task automatic write_cmd_wait(input logic [WAIT_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cmd_wait = value;
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [1:0] pick_op(input int tick_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return OP_UNUSED;
        else if (r < 4 + tick_pct)
            return OP_TICK;
        else if ($urandom_range(0, 1) == 0)
            return OP_PUSH_CHAR;
        else
            return OP_PUSH_CMD;
    endfunction

    task automatic run_mix(input int n, input int tick_pct);
        for (int i = 0; i < n; i++)
            send_item(pick_op(tick_pct), BYTE_W'($urandom_range(0, 255)), 1'b0, NO_RES);
    endtask

    // Receiver side: random stall bursts while idles are enabled
    always @(posedge aclk) begin
        if (idle_on && rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_lcd_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", got);
                mismatch_count++;
            end else begin
                want = pending_lcd_results.pop_front();
                if (got.strobe !== want.strobe) begin
                    $error("write_strobe: expected %0d, got %0d", want.strobe, got.strobe);
                    mismatch_count++;
                end
                if (got.rs !== want.rs) begin
                    $error("register_select: expected %0d, got %0d", want.rs, got.rs);
                    mismatch_count++;
                end
                if (got.lcd !== want.lcd) begin
                    $error("lcd_byte: expected %h, got %h", want.lcd, got.lcd);
                    mismatch_count++;
                end
                if (got.led !== want.led) begin
                    $error("led_drive: expected %h, got %h", want.led, got.led);
                    mismatch_count++;
                end
                if (got.dropped !== want.dropped) begin
                    $error("push_dropped: expected %0d, got %0d", want.dropped, got.dropped);
                    mismatch_count++;
                end
                if (got.fill !== want.fill) begin
                    $error("queue_fill: expected %0d, got %0d", want.fill, got.fill);
                    mismatch_count++;
                end
                if (got.pad !== want.pad) begin
                    $error("pad: expected %h, got %h", want.pad, got.pad);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rd_pos      = '0;
        wr_pos      = '0;
        queued      = '0;
        pause_ticks = '0;
        chaser      = '0;
        cmd_wait    = CMD_WAIT_RESET;

        // Directed part, reset wait of 4 still in place
        directed_rows = '{
            // first tick lights the chaser, empty queue writes nothing
            {OP_TICK,      8'h00, 1'b1, lcd_res(1'b0, 1'b0, 8'h00, 8'hFE, 1'b0, 10'd0)},
            {OP_PUSH_CHAR, 8'h00, 1'b1, lcd_res(1'b0, 1'b0, 8'h00, 8'hFE, 1'b0, 10'd1)},
            {OP_PUSH_CMD,  8'hFF, 1'b1, lcd_res(1'b0, 1'b0, 8'h00, 8'hFE, 1'b0, 10'd2)},
            {OP_UNUSED,    8'hAA, 1'b1, lcd_res(1'b0, 1'b0, 8'h00, 8'hFE, 1'b0, 10'd2)},
            {OP_TICK,      8'h5A, 1'b1, lcd_res(1'b1, 1'b1, 8'h00, 8'hFD, 1'b0, 10'd1)},
            {OP_TICK,      8'h00, 1'b1, lcd_res(1'b1, 1'b0, 8'hFF, 8'hFB, 1'b0, 10'd0)},
            // wait counter holds while empty
            {OP_TICK,      8'h00, 1'b1, lcd_res(1'b0, 1'b0, 8'h00, 8'hF7, 1'b0, 10'd0)},
            {OP_PUSH_CHAR, 8'hFF, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            // chaser wraps from bit 7 back to bit 0
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_PUSH_CMD,  8'h00, 1'b0, NO_RES},
            {OP_PUSH_CHAR, 8'h80, 1'b0, NO_RES},
            {OP_PUSH_CMD,  8'h01, 1'b0, NO_RES},
            {OP_UNUSED,    8'h55, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'hFF, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES},
            {OP_TICK,      8'h00, 1'b0, NO_RES}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].din,
                      directed_rows[i].known, directed_rows[i].want);

        // No pause after commands
        write_cmd_wait('0);
        run_mix(110, 45);

        // Longest pause
        write_cmd_wait('1);
        run_mix(110, 45);

        // Fill to the top, then keep it there so pushes get refused
        write_cmd_wait(WAIT_W'($urandom_range(1, 14)));
        while (queued < CNT_W'(QUEUE_DEPTH))
            send_item(($urandom_range(0, 19) == 0) ? OP_TICK : pick_op(0),
                      BYTE_W'($urandom_range(0, 255)), 1'b0, NO_RES);
        repeat (8)
            send_item(pick_op(0), BYTE_W'($urandom_range(0, 255)), 1'b0, NO_RES);
        run_mix(80, 35);

        // Closing stretch at full rate
        write_cmd_wait(WAIT_W'(1));
        idle_on = 1'b0;
        run_mix(50, 45);

        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
